[rtl/qte_pkg.sv]
package qte_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN          = 24;

    localparam int QW  = 16;   // quaternion component width
    localparam int AW  = 36;   // accumulator / CORDIC vector width
    localparam int ZW  = 25;   // CORDIC angle accumulator, Q.20
    localparam int MW  = 32;   // serial multiplier operand width
    localparam int MD  = 4;    // multiplier digit width
    localparam int PW  = 2 * MW;

    localparam logic signed [ZW-1:0] PI_Q20      = 25'sd3294199;
    localparam logic signed [17:0]   PI_Q13      = 18'sd25736;
    localparam logic signed [17:0]   HALF_PI_Q13 = 18'sd12868;

    localparam logic [3:0] PIDX_LAST = 4'd9;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MWAIT,
        S_YAW,
        S_YWAIT,
        S_ROLL,
        S_RWAIT,
        S_PCHK,
        S_SMUL,
        S_SMWAIT,
        S_SQRT,
        S_SQWAIT,
        S_PCOR,
        S_PWAIT,
        S_DONE
    } state_t;

    // atan(2^-i) in Q.20
    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:    r = 25'sd823550;
            5'd1:    r = 25'sd486170;
            5'd2:    r = 25'sd256879;
            5'd3:    r = 25'sd130396;
            5'd4:    r = 25'sd65451;
            5'd5:    r = 25'sd32757;
            5'd6:    r = 25'sd16383;
            5'd7:    r = 25'sd8192;
            5'd8:    r = 25'sd4096;
            5'd9:    r = 25'sd2048;
            5'd10:   r = 25'sd1024;
            5'd11:   r = 25'sd512;
            5'd12:   r = 25'sd256;
            5'd13:   r = 25'sd128;
            5'd14:   r = 25'sd64;
            5'd15:   r = 25'sd32;
            5'd16:   r = 25'sd16;
            5'd17:   r = 25'sd8;
            5'd18:   r = 25'sd4;
            5'd19:   r = 25'sd2;
            5'd20:   r = 25'sd1;
            default: r = 25'sd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/qte_mul.sv]
// Unsigned shift-add multiplier, one MD-bit digit of b per cycle.
module qte_mul
    import qte_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [MW-1:0] a,
    input  logic [MW-1:0] b,
    output logic [PW-1:0] p,
    output logic          done
);

    localparam int NDIG = MW / MD;
    localparam int CW   = $clog2(NDIG);
    localparam int SW   = MW + 1 + MD;

    logic [MW:0]    hi_reg, hi_next;
    logic [MW-1:0]  lo_reg, lo_next;
    logic [MW-1:0]  a_reg, a_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [SW-1:0]  sum;

    assign sum = SW'(hi_reg) + SW'(a_reg * lo_reg[MD-1:0]);

    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            hi_next   = '0;
            lo_next   = b;
            a_next    = a;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[SW-1:MD];
            lo_next  = {sum[MD-1:0], lo_reg[MW-1:MD]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NDIG - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        a_reg  <= a_next;
    end

    assign p    = {hi_reg[MW-1:0], lo_reg};
    assign done = done_reg;

endmodule

[rtl/qte_isqrt.sv]
// Floor square root, one result bit (two radicand bits) per cycle.
module qte_isqrt
    import qte_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [PW-1:0] v,
    output logic [MW-1:0] root,
    output logic          done
);

    localparam int CW = $clog2(MW);
    localparam int RW = MW + 3;

    logic [PW-1:0] v_reg, v_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [MW-1:0] root_reg, root_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW-1:0] rem_sh, trial;

    assign rem_sh = {rem_reg[RW-3:0], v_reg[PW-1:PW-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = v;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next   = {v_reg[PW-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[MW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[MW-2:0], 1'b0};
            end
            if (cnt_reg == CW'(MW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

[rtl/qte_cordic.sv]
// Vectoring CORDIC atan2, one iteration per cycle; result Q2.13, clamped to +-pi.
module qte_cordic
    import qte_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [AW-1:0] y,
    input  logic signed [AW-1:0] x,
    output logic signed [15:0]   angle,
    output logic                 done
);

    localparam int NIT = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;

    logic signed [AW-1:0] x_reg, x_next;
    logic signed [AW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [4:0]           i_reg, i_next;
    logic                 busy_reg, busy_next;
    logic                 fin_reg, fin_next;
    logic                 done_reg, done_next;
    logic signed [15:0]   ang_reg, ang_next;
    logic signed [AW-1:0] xs, ys;
    logic signed [17:0]   zr;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign zr = 18'((z_reg + ZW'(64)) >>> 7);

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        ang_next  = ang_reg;
        if (start)
        begin
            i_next = '0;
            if (x == '0 && y == '0)
            begin
                ang_next  = '0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                if (x < 0)
                begin
                    x_next = -x;
                    y_next = -y;
                    z_next = (y >= 0) ? PI_Q20 : -PI_Q20;
                end
                else
                begin
                    x_next = x;
                    y_next = y;
                    z_next = '0;
                end
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_tab(i_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_tab(i_reg);
            end
            i_next = i_reg + 1'b1;
            if (i_reg == 5'(NIT - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
            if (zr > PI_Q13)
                ang_next = 16'(PI_Q13);
            else if (zr < -PI_Q13)
                ang_next = 16'(-PI_Q13);
            else
                ang_next = 16'(zr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        ang_reg <= ang_next;
    end

    assign angle = ang_reg;
    assign done  = done_reg;

endmodule

[rtl/quaternion_to_euler.sv]
// Channel   Dir  Fields (low bit up)                           Handshake
// s_axis    in   tdata: q_real, q_i, q_j, q_k (64b)            s_tvalid/s_tready
//                tuser: sample_valid
// m_axis    out  tdata: roll, pitch(15b), yaw, 1 pad (48b)     m_tvalid/m_tready
//
// A hold item (sample_valid low) skips the work and resends the held angles.
// A new report runs ten digit-serial products, CORDIC passes for yaw and
// roll and, unless pitch saturates or the norm is zero, an asin-radicand
// product, a square root and a pitch CORDIC pass, all on single shared units.
// One item is in flight at a time; the finished item sits in the output
// register while the next one is accepted and worked on.
// rst_n clears control and the held angles; a stalled m_tready holds the result.
module quaternion_to_euler
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // q_real, q_i, q_j, q_k
    input  logic        s_tuser,   // sample_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // roll, pitch, yaw, zero pad
);

    state_t state_reg, state_next;

    // captured quaternion
    logic signed [QW-1:0] q_reg [4];
    logic [3:0]           pidx_reg, pidx_next;

    // running sums of the product terms
    logic signed [AW-1:0] yx_reg, yx_next;   // yaw x
    logic signed [AW-1:0] rx_reg, rx_next;   // roll x
    logic signed [AW-1:0] yy_reg, yy_next;   // yaw y / 2
    logic signed [AW-1:0] ry_reg, ry_next;   // roll y / 2
    logic signed [AW-1:0] pn_reg, pn_next;   // pitch numerator / 2
    logic signed [AW-1:0] nn_reg, nn_next;   // squared norm

    logic [30:0] as_reg, as_next, ns_reg, ns_next;
    logic        neg_reg, neg_next;

    logic signed [15:0] h_roll_reg, h_roll_next;
    logic signed [14:0] h_pitch_reg, h_pitch_next;
    logic signed [15:0] h_yaw_reg, h_yaw_next;

    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;

    // shared units
    logic          mul_start, mul_done;
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic          sq_start, sq_done;
    logic [MW-1:0] sq_root;
    logic          cor_start, cor_done;
    logic signed [AW-1:0] cor_y, cor_x;
    logic signed [15:0]   cor_ang;

    logic [PW-1:0] sqrt_in;
    logic          accept;

    // operand selection for the product schedule
    logic [1:0]           sel_a, sel_b;
    logic [QW-1:0]        mag_a, mag_b;
    logic                 prod_neg;
    logic signed [AW-1:0] sprod;

    // pitch range check
    logic signed [AW-1:0] num;
    logic [AW-1:0]        a_mag;

    qte_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .done  (mul_done)
    );

    qte_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .v     (sqrt_in),
        .root  (sq_root),
        .done  (sq_done)
    );

    qte_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y     (cor_y),
        .x     (cor_x),
        .angle (cor_ang),
        .done  (cor_done)
    );

    assign accept  = s_tvalid && s_tready;
    assign sqrt_in = mul_p;

    // product order: r*r, i*i, j*j, k*k, i*j, k*r, j*k, i*r, i*k, j*r
    // component index: 0 real, 1 i, 2 j, 3 k
    always_comb
    begin
        case (pidx_reg)
            4'd0:    begin sel_a = 2'd0; sel_b = 2'd0; end
            4'd1:    begin sel_a = 2'd1; sel_b = 2'd1; end
            4'd2:    begin sel_a = 2'd2; sel_b = 2'd2; end
            4'd3:    begin sel_a = 2'd3; sel_b = 2'd3; end
            4'd4:    begin sel_a = 2'd1; sel_b = 2'd2; end
            4'd5:    begin sel_a = 2'd3; sel_b = 2'd0; end
            4'd6:    begin sel_a = 2'd2; sel_b = 2'd3; end
            4'd7:    begin sel_a = 2'd1; sel_b = 2'd0; end
            4'd8:    begin sel_a = 2'd1; sel_b = 2'd3; end
            default: begin sel_a = 2'd2; sel_b = 2'd0; end
        endcase
    end

    assign mag_a    = q_reg[sel_a][QW-1] ? QW'(-q_reg[sel_a]) : QW'(q_reg[sel_a]);
    assign mag_b    = q_reg[sel_b][QW-1] ? QW'(-q_reg[sel_b]) : QW'(q_reg[sel_b]);
    assign prod_neg = q_reg[sel_a][QW-1] ^ q_reg[sel_b][QW-1];
    assign sprod    = prod_neg ? -$signed(AW'(mul_p[30:0])) : $signed(AW'(mul_p[30:0]));

    assign num   = pn_reg <<< 1;
    assign a_mag = num < 0 ? AW'(-num) : AW'(num);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = s_tuser ? S_MUL : S_DONE;
            S_MUL:    state_next = S_MWAIT;
            S_MWAIT:  if (mul_done) state_next = (pidx_reg == PIDX_LAST) ? S_YAW : S_MUL;
            S_YAW:    state_next = S_YWAIT;
            S_YWAIT:  if (cor_done) state_next = S_ROLL;
            S_ROLL:   state_next = S_RWAIT;
            S_RWAIT:  if (cor_done) state_next = S_PCHK;
            S_PCHK:
            begin
                if (nn_reg == '0 || a_mag >= AW'(nn_reg))
                    state_next = S_DONE;
                else
                    state_next = S_SMUL;
            end
            S_SMUL:   state_next = S_SMWAIT;
            S_SMWAIT: if (mul_done) state_next = S_SQRT;
            S_SQRT:   state_next = S_SQWAIT;
            S_SQWAIT: if (sq_done) state_next = S_PCOR;
            S_PCOR:   state_next = S_PWAIT;
            S_PWAIT:  if (cor_done) state_next = S_DONE;
            S_DONE:   if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // unit control and operands
    always_comb
    begin
        s_tready  = (state_reg == S_IDLE);
        mul_start = (state_reg == S_MUL) || (state_reg == S_SMUL);
        sq_start  = (state_reg == S_SQRT);
        cor_start = (state_reg == S_YAW) || (state_reg == S_ROLL) || (state_reg == S_PCOR);
        if (state_reg == S_SMUL)
        begin
            mul_a = MW'(ns_reg - as_reg);
            mul_b = MW'(ns_reg) + MW'(as_reg);
        end
        else
        begin
            mul_a = MW'(mag_a);
            mul_b = MW'(mag_b);
        end
        case (state_reg)
            S_ROLL:
            begin
                cor_y = ry_reg <<< 1;
                cor_x = rx_reg;
            end
            S_PCOR:
            begin
                cor_y = neg_reg ? -$signed(AW'(as_reg)) : $signed(AW'(as_reg));
                cor_x = $signed(AW'(sq_root));
            end
            default:
            begin
                cor_y = yy_reg <<< 1;
                cor_x = yx_reg;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        pidx_next    = pidx_reg;
        yx_next      = yx_reg;
        rx_next      = rx_reg;
        yy_next      = yy_reg;
        ry_next      = ry_reg;
        pn_next      = pn_reg;
        nn_next      = nn_reg;
        as_next      = as_reg;
        ns_next      = ns_reg;
        neg_next     = neg_reg;
        h_roll_next  = h_roll_reg;
        h_pitch_next = h_pitch_reg;
        h_yaw_next   = h_yaw_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                pidx_next = '0;
                yx_next   = '0;
                rx_next   = '0;
                yy_next   = '0;
                ry_next   = '0;
                pn_next   = '0;
                nn_next   = '0;
            end
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    pidx_next = pidx_reg + 1'b1;
                    case (pidx_reg)
                        4'd0:
                        begin
                            yx_next = yx_reg + sprod;
                            rx_next = rx_reg + sprod;
                            nn_next = nn_reg + sprod;
                        end
                        4'd1:
                        begin
                            yx_next = yx_reg + sprod;
                            rx_next = rx_reg - sprod;
                            nn_next = nn_reg + sprod;
                        end
                        4'd2:
                        begin
                            yx_next = yx_reg - sprod;
                            rx_next = rx_reg - sprod;
                            nn_next = nn_reg + sprod;
                        end
                        4'd3:
                        begin
                            yx_next = yx_reg - sprod;
                            rx_next = rx_reg + sprod;
                            nn_next = nn_reg + sprod;
                        end
                        4'd4, 4'd5: yy_next = yy_reg + sprod;
                        4'd6, 4'd7: ry_next = ry_reg + sprod;
                        4'd8:       pn_next = pn_reg - sprod;
                        default:    pn_next = pn_reg + sprod;
                    endcase
                end
            end
            S_YWAIT: if (cor_done) h_yaw_next = cor_ang;
            S_RWAIT: if (cor_done) h_roll_next = cor_ang;
            S_PCHK:
            begin
                neg_next = num < 0;
                as_next  = a_mag[32:2];
                ns_next  = nn_reg[32:2];
                if (nn_reg == '0)
                    h_pitch_next = '0;
                else if (a_mag >= AW'(nn_reg))
                    h_pitch_next = (num < 0) ? 15'(-HALF_PI_Q13) : 15'(HALF_PI_Q13);
            end
            S_PWAIT:
            begin
                if (cor_done)
                begin
                    if (cor_ang > 16'(HALF_PI_Q13))
                        h_pitch_next = 15'(HALF_PI_Q13);
                    else if (cor_ang < 16'(-HALF_PI_Q13))
                        h_pitch_next = 15'(-HALF_PI_Q13);
                    else
                        h_pitch_next = 15'(cor_ang);
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, h_yaw_reg, h_pitch_reg, h_roll_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pidx_reg    <= '0;
            m_valid_reg <= 1'b0;
            h_roll_reg  <= '0;
            h_pitch_reg <= '0;
            h_yaw_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pidx_reg    <= pidx_next;
            m_valid_reg <= m_valid_next;
            h_roll_reg  <= h_roll_next;
            h_pitch_reg <= h_pitch_next;
            h_yaw_reg   <= h_yaw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[0] <= s_tdata[15:0];
            q_reg[1] <= s_tdata[31:16];
            q_reg[2] <= s_tdata[47:32];
            q_reg[3] <= s_tdata[63:48];
        end
        yx_reg     <= yx_next;
        rx_reg     <= rx_next;
        yy_reg     <= yy_next;
        ry_reg     <= ry_next;
        pn_reg     <= pn_next;
        nn_reg     <= nn_next;
        as_reg     <= as_next;
        ns_reg     <= ns_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
